// File: src/n_queens_nth_solution_unit_assert.svh
// Assertion macros for the n-queens nth-solution unit.
// Used by the RTL files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef N_QUEENS_NTH_SOLUTION_UNIT_ASSERT_SVH
`define N_QUEENS_NTH_SOLUTION_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define NQNS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nqns assertion failed");
`define NQNS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nqns assertion failed");
`else
`define NQNS_ASSERT_IMP(lbl, ante, cons)
`define NQNS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: src/nqns_pkg.sv
// Package for the n-queens nth-solution unit: sizes, controller states and the
// command and status structures between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nqns_pkg;

  localparam int BOARD_SIZE = 8;
  localparam int MAX_ROWS   = 9;
  localparam int ROW_W      = 4;
  localparam int COL_W      = 4;
  localparam int ADDR_W     = 4;
  localparam int QIDX_W     = 9;
  localparam int CODE_W     = 30;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INC,
    S_CHECK,
    S_LOAD,
    S_ENC,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    logic inc;
    logic check;
    logic place;
    logic load;
    logic enc;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_zero;
    logic col_over;
    logic row_is_one;
    logic chk_fail;
    logic chk_pass;
    logic sol_hit;
    logic enc_done;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// File: src/n_queens_nth_solution_unit.sv
// Top level of the n-queens nth-solution unit.
// Depends on nqns_pkg, nqns_ctrl and nqns_datapath.
//
//   Channel  Ports                                   Direction  Handshake
//   in       in_query_index                          input      in_valid / in_ready
//   out      out_solution_code, out_found            output     out_valid / out_ready
//
// One query is searched at a time; in_ready is high only while the unit is idle.
// A candidate column is checked against the earlier rows, which are read one per
// cycle from the single read port of the column store; a backtrack reads the previous
// row's column back from the store, and a found solution is encoded column by column.
// Reset clears the controller and the output valid flag; the column store needs no clearing.
// A finished result waits in the output register while out_ready is low.
`timescale 1ns / 1ps
`default_nettype none
module n_queens_nth_solution_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [nqns_pkg::QIDX_W-1:0] in_query_index,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [nqns_pkg::CODE_W-1:0]      out_solution_code,
  output logic                             out_found
);
  import nqns_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  nqns_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  nqns_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_query_index    (in_query_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_solution_code (out_solution_code),
    .out_found         (out_found)
  );

endmodule
`default_nettype wire

// File: src/nqns_ctrl.sv
// Controller state machine of the n-queens nth-solution unit.
// Depends on nqns_pkg; drives commands to nqns_datapath and reads its status.
`timescale 1ns / 1ps
`default_nettype none
module nqns_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire nqns_pkg::dp_status_t status,
  output nqns_pkg::ctl_cmd_t       cmd
);
  import nqns_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = status.in_zero ? S_FINISH : S_INC;
        end
      end
      S_INC: begin
        if (!status.col_over) begin
          state_nxt = S_CHECK;
        end else if (status.row_is_one) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_CHECK: begin
        if (status.chk_fail) begin
          state_nxt = S_INC;
        end else if (status.chk_pass) begin
          state_nxt = status.sol_hit ? S_ENC : S_INC;
        end
      end
      S_LOAD: begin
        state_nxt = S_INC;
      end
      S_ENC: begin
        if (status.enc_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_ready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      S_INC: begin
        cmd.inc = 1'b1;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        cmd.place = status.chk_pass && !status.chk_fail;
      end
      S_LOAD: begin
        cmd.load = 1'b1;
      end
      S_ENC: begin
        cmd.enc = 1'b1;
      end
      S_FINISH: begin
        cmd.out_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: src/nqns_datapath.sv
// Datapath of the n-queens nth-solution unit: row and column registers, the
// column store, the diagonal check, the decimal encoder and the result register.
// Depends on nqns_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "n_queens_nth_solution_unit_assert.svh"
module nqns_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire nqns_pkg::ctl_cmd_t          cmd,
  output nqns_pkg::dp_status_t             status,
  input  wire logic [nqns_pkg::QIDX_W-1:0] in_query_index,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [nqns_pkg::CODE_W-1:0]      out_solution_code,
  output logic                             out_found
);
  import nqns_pkg::*;

  logic [COL_W-1:0]  qcol_mem [MAX_ROWS];
  logic [COL_W-1:0]  rd_r;
  logic [ROW_W-1:0]  row_r;
  logic [ROW_W-1:0]  row_nxt;
  logic [COL_W-1:0]  col_r;
  logic [COL_W-1:0]  col_nxt;
  logic [ROW_W-1:0]  j_r;
  logic [ROW_W-1:0]  j_nxt;
  logic [ROW_W-1:0]  dist_r;
  logic [ROW_W-1:0]  dist_nxt;
  logic              pend_r;
  logic              pend_nxt;
  logic [ROW_W-1:0]  k_r;
  logic [ROW_W-1:0]  k_nxt;
  logic              epend_r;
  logic              epend_nxt;
  logic [QIDX_W-1:0] want_r;
  logic [QIDX_W-1:0] cnt_r;
  logic [QIDX_W-1:0] cnt_nxt;
  logic [QIDX_W-1:0] cnt_inc;
  logic [CODE_W-1:0] code_r;
  logic [CODE_W-1:0] code_nxt;
  logic              hit_r;
  logic              hit_nxt;
  logic              out_valid_r;
  logic [CODE_W-1:0] out_code_r;
  logic              out_found_r;
  logic [COL_W:0]    col_inc;
  logic              col_over;
  logic [COL_W-1:0]  diff;
  logic              bad;
  logic              chk_issue;
  logic              enc_issue;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              last_row;
  logic              sol_hit;

  assign col_inc  = {1'b0, col_r} + (COL_W + 1)'(1);
  assign col_over = col_inc > (COL_W + 1)'(BOARD_SIZE);
  assign diff     = (col_r >= rd_r) ? (col_r - rd_r) : (rd_r - col_r);
  assign bad      = pend_r && ((diff == '0) || (diff == dist_r));
  assign chk_issue = j_r < row_r;
  assign enc_issue = k_r < ROW_W'(BOARD_SIZE);
  assign cnt_inc  = cnt_r + QIDX_W'(1);
  assign last_row = row_r == ROW_W'(BOARD_SIZE);
  assign sol_hit  = last_row && (cnt_inc == want_r);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd.inc && col_over && (row_r != ROW_W'(1))) begin
      rd_en   = 1'b1;
      rd_addr = ADDR_W'(row_r - ROW_W'(2));
    end else if (cmd.check && chk_issue) begin
      rd_en   = 1'b1;
      rd_addr = ADDR_W'(j_r - ROW_W'(1));
    end else if (cmd.enc && enc_issue) begin
      rd_en   = 1'b1;
      rd_addr = ADDR_W'(k_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.place) begin
      qcol_mem[ADDR_W'(row_r - ROW_W'(1))] <= col_r;
    end
    if (rd_en) begin
      rd_r <= qcol_mem[rd_addr];
    end
  end

  always_comb begin
    row_nxt   = row_r;
    col_nxt   = col_r;
    j_nxt     = j_r;
    dist_nxt  = dist_r;
    pend_nxt  = pend_r;
    k_nxt     = k_r;
    epend_nxt = epend_r;
    cnt_nxt   = cnt_r;
    code_nxt  = code_r;
    hit_nxt   = hit_r;
    if (cmd.start) begin
      row_nxt  = ROW_W'(1);
      col_nxt  = '0;
      cnt_nxt  = '0;
      code_nxt = '0;
      hit_nxt  = 1'b0;
    end
    if (cmd.inc) begin
      if (col_over) begin
        row_nxt = row_r - ROW_W'(1);
      end else begin
        col_nxt  = col_inc[COL_W-1:0];
        j_nxt    = ROW_W'(1);
        pend_nxt = 1'b0;
      end
    end
    if (cmd.load) begin
      col_nxt = rd_r;
    end
    if (cmd.check) begin
      pend_nxt = chk_issue;
      if (chk_issue) begin
        dist_nxt = row_r - j_r;
        j_nxt    = j_r + ROW_W'(1);
      end
    end
    if (cmd.place) begin
      k_nxt     = '0;
      epend_nxt = 1'b0;
      if (last_row) begin
        cnt_nxt = cnt_inc;
        hit_nxt = sol_hit;
      end else begin
        row_nxt = row_r + ROW_W'(1);
        col_nxt = '0;
      end
    end
    if (cmd.enc) begin
      epend_nxt = enc_issue;
      if (enc_issue) begin
        k_nxt = k_r + ROW_W'(1);
      end
      if (epend_r) begin
        code_nxt = (code_r << 3) + (code_r << 1) + CODE_W'(rd_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      j_r         <= '0;
      pend_r      <= 1'b0;
      k_r         <= '0;
      epend_r     <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      j_r     <= j_nxt;
      pend_r  <= pend_nxt;
      k_r     <= k_nxt;
      epend_r <= epend_nxt;
      hit_r   <= hit_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
    cnt_r  <= cnt_nxt;
    code_r <= code_nxt;
    if (cmd.start) begin
      want_r <= in_query_index;
    end
    if (cmd.out_load) begin
      out_code_r  <= hit_r ? code_r : '0;
      out_found_r <= hit_r;
    end
  end

  always_comb begin
    status.in_zero    = in_query_index == '0;
    status.col_over   = col_over;
    status.row_is_one = row_r == ROW_W'(1);
    status.chk_fail   = bad;
    status.chk_pass   = !bad && (j_r == row_r);
    status.sol_hit    = sol_hit;
    status.enc_done   = epend_r && (k_r == ROW_W'(BOARD_SIZE));
    status.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid         = out_valid_r;
  assign out_solution_code = out_code_r;
  assign out_found         = out_found_r;

  `NQNS_ASSERT_IMP(a_row_range, 1'b1, row_r <= ROW_W'(BOARD_SIZE))
  `NQNS_ASSERT_IMP(a_col_range, 1'b1, col_r <= COL_W'(BOARD_SIZE))
  `NQNS_ASSERT_IMP(a_miss_zero, out_valid_r && !out_found_r, out_solution_code == '0)
  `NQNS_ASSERT_IMP(a_place_clean, cmd.place, !pend_r || !bad)
  `NQNS_ASSERT_NXT(a_hit_sticks, cmd.place && sol_hit, hit_r)

endmodule
`default_nettype wire
